/* sv/sds_pkg.sv */
`default_nettype none

package sds_pkg;

    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic STACK_LOWER = 1'b0;
    localparam logic STACK_UPPER = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } ram_req_t;

    typedef struct packed {
        logic    pop_ok;
        status_t status;
    } item_info_t;

endpackage

`default_nettype wire

/* sv/sds_ram.sv */
`default_nettype none

module sds_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [DATA_W-1:0] wdata,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

/* sv/sds_ctrl.sv */
`default_nettype none

module sds_ctrl (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         accept,
    input  wire logic                         operation,
    input  wire logic                         which_stack,
    input  wire logic [sds_pkg::DATA_W-1:0]   push_value,
    output sds_pkg::ram_req_t                 ram_req,
    output sds_pkg::item_info_t               info
);

    localparam logic [sds_pkg::CNT_W-1:0] DEPTH_C = sds_pkg::CNT_W'(sds_pkg::DEPTH);
    localparam logic [sds_pkg::CNT_W-1:0] TOP_C   = sds_pkg::CNT_W'(sds_pkg::DEPTH - 1);
    localparam logic [sds_pkg::CNT_W-1:0] ONE_C   = sds_pkg::CNT_W'(1);

    logic [sds_pkg::CNT_W-1:0] lower_count_reg, lower_count_next;
    logic [sds_pkg::CNT_W-1:0] upper_count_reg, upper_count_next;
    logic [sds_pkg::CNT_W-1:0] total;
    logic [sds_pkg::CNT_W-1:0] addr_wide;
    logic                      full;

    assign total = lower_count_reg + upper_count_reg;
    assign full  = (total == DEPTH_C);

    always_comb begin
        lower_count_next = lower_count_reg;
        upper_count_next = upper_count_reg;
        addr_wide        = '0;
        ram_req.we       = 1'b0;
        ram_req.re       = 1'b0;
        ram_req.wdata    = push_value;
        info.pop_ok      = 1'b0;
        info.status      = sds_pkg::ST_OK;

        if (operation == sds_pkg::OP_PUSH) begin
            if (full) begin
                info.status = sds_pkg::ST_OVERFLOW;
            end else if (which_stack == sds_pkg::STACK_LOWER) begin
                addr_wide        = lower_count_reg;
                ram_req.we       = accept;
                lower_count_next = lower_count_reg + ONE_C;
            end else begin
                addr_wide        = TOP_C - upper_count_reg;
                ram_req.we       = accept;
                upper_count_next = upper_count_reg + ONE_C;
            end
        end else begin
            if (which_stack == sds_pkg::STACK_LOWER) begin
                if (lower_count_reg == '0) begin
                    info.status = sds_pkg::ST_UNDERFLOW;
                end else begin
                    addr_wide        = lower_count_reg - ONE_C;
                    ram_req.re       = accept;
                    info.pop_ok      = 1'b1;
                    lower_count_next = lower_count_reg - ONE_C;
                end
            end else begin
                if (upper_count_reg == '0) begin
                    info.status = sds_pkg::ST_UNDERFLOW;
                end else begin
                    addr_wide        = DEPTH_C - upper_count_reg;
                    ram_req.re       = accept;
                    info.pop_ok      = 1'b1;
                    upper_count_next = upper_count_reg - ONE_C;
                end
            end
        end

        ram_req.addr = addr_wide[sds_pkg::ADDR_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lower_count_reg <= '0;
            upper_count_reg <= '0;
        end else if (accept) begin
            lower_count_reg <= lower_count_next;
            upper_count_reg <= upper_count_next;
        end
    end

endmodule

`default_nettype wire

/* sv/shared_dual_stack.sv */
// Two LIFO stacks in one 1024-word memory: the lower stack fills upward from
// word 0 and the upper stack downward from the top word. Each transaction on
// the slave side is a push or a pop on one stack and gives exactly one
// transaction on the master side, carrying the popped word and a status. A
// push while both stacks together hold every word is refused with overflow,
// and a pop from an empty stack returns zero with underflow. The block takes
// one transaction per cycle while results are being taken. The memory read and
// the status of a transaction are registered at the edge that accepts it, and
// the output register loads from them when it is empty or its result is taken.
// While a result waits, one further transaction can be accepted and held, after
// which the slave side stalls until the result is taken.

`default_nettype none

module shared_dual_stack (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [31:0]                s_tdata,  // push_value
    input  wire logic [1:0]                 s_tuser,  // which_stack, operation
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic      [31:0]                m_tdata,  // pop_value
    output logic      [1:0]                 m_tuser   // status
);

    sds_pkg::ram_req_t            ram_req;
    sds_pkg::item_info_t          info;
    logic [sds_pkg::DATA_W-1:0]   rdata;
    logic                         accept;
    logic                         out_free;
    logic                         p1_move;

    logic                         p1_valid_reg;
    logic                         p1_pop_reg;
    sds_pkg::status_t             p1_status_reg;
    logic                         out_valid_reg;
    logic [sds_pkg::DATA_W-1:0]   out_data_reg;
    sds_pkg::status_t             out_status_reg;

    assign out_free = !out_valid_reg || m_tready;
    assign p1_move  = p1_valid_reg && out_free;
    assign s_tready = !p1_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    sds_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .operation   (s_tuser[0]),
        .which_stack (s_tuser[1]),
        .push_value  (s_tdata),
        .ram_req     (ram_req),
        .info        (info)
    );

    sds_ram #(
        .DATA_W (sds_pkg::DATA_W),
        .DEPTH  (sds_pkg::DEPTH),
        .ADDR_W (sds_pkg::ADDR_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_req.we),
        .re    (ram_req.re),
        .addr  (ram_req.addr),
        .wdata (ram_req.wdata),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                p1_valid_reg <= 1'b1;
            end else if (p1_move) begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_move) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_pop_reg    <= info.pop_ok;
            p1_status_reg <= info.status;
        end
        if (p1_move) begin
            out_data_reg   <= p1_pop_reg ? rdata : '0;
            out_status_reg <= p1_status_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

endmodule

`default_nettype wire

/* sv/sds_checker.sv */
`default_nettype none

module sds_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    logic in_xfer;

    assign in_xfer = s_tvalid && s_tready;

    // A status code outside the defined three never leaves the block.
    a_status_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == sds_pkg::ST_OK || m_tuser == sds_pkg::ST_OVERFLOW ||
                      m_tuser == sds_pkg::ST_UNDERFLOW))
        else $error("illegal status code on result");

    // A refused push or a failed pop carries a zero word.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != sds_pkg::ST_OK) |-> (m_tdata == 32'd0))
        else $error("failed transaction carries a non-zero word");

    // No result can appear on an idle output without an earlier accepted transaction.
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(!m_tvalid) && $past(!in_xfer, 2) && $past(!in_xfer)) |-> !m_tvalid)
        else $error("result appeared without a transaction");

    // A stalled result holds its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind shared_dual_stack sds_checker u_sds_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [sds_pkg::DATA_W-1:0] pop_value;
        sds_pkg::status_t           status;
    } stack_result_t;

    class dual_stack_scoreboard;
        logic [sds_pkg::DATA_W-1:0] shared_words [sds_pkg::DEPTH];
        int unsigned       lower_held;
        int unsigned       upper_held;
        int unsigned       peak_held;
        stack_result_t     expected_results [$];
        int unsigned       mismatches;
        int unsigned       results_seen;
        int unsigned       overflows;
        int unsigned       underflows;
        int unsigned       good_pops;

        function void apply_stack_op(logic op, logic which,
                                     logic [sds_pkg::DATA_W-1:0] value);
            stack_result_t r;
            r.pop_value = '0;
            r.status    = sds_pkg::ST_OK;
            if (op == sds_pkg::OP_PUSH) begin
                if (lower_held + upper_held >= sds_pkg::DEPTH) begin
                    r.status = sds_pkg::ST_OVERFLOW;
                    overflows++;
                end else if (which == sds_pkg::STACK_LOWER) begin
                    shared_words[lower_held] = value;
                    lower_held++;
                end else begin
                    shared_words[sds_pkg::DEPTH - 1 - upper_held] = value;
                    upper_held++;
                end
                if (lower_held + upper_held > peak_held) begin
                    peak_held = lower_held + upper_held;
                end
            end else if (which == sds_pkg::STACK_LOWER) begin
                if (lower_held == 0) begin
                    r.status = sds_pkg::ST_UNDERFLOW;
                    underflows++;
                end else begin
                    lower_held--;
                    r.pop_value = shared_words[lower_held];
                    good_pops++;
                end
            end else begin
                if (upper_held == 0) begin
                    r.status = sds_pkg::ST_UNDERFLOW;
                    underflows++;
                end else begin
                    upper_held--;
                    r.pop_value = shared_words[sds_pkg::DEPTH - 1 - upper_held];
                    good_pops++;
                end
            end
            expected_results.push_back(r);
        endfunction

        function void check_result(logic [sds_pkg::DATA_W-1:0] pop_value, logic [1:0] status);
            stack_result_t want;
            if (expected_results.size() == 0) begin
                if (mismatches < 10) begin
                    $display("Unexpected transaction: pop_value %h status %0d",
                             pop_value, status);
                end
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            if (pop_value !== want.pop_value || status !== 2'(want.status)) begin
                if (mismatches < 10) begin
                    $display("Result %0d: expected pop_value %h status %0d, got %h status %0d",
                             results_seen, want.pop_value, want.status, pop_value, status);
                end
                mismatches++;
            end
            results_seen++;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                       aclk     = 1'b0;
    logic                       aresetn  = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [sds_pkg::DATA_W-1:0] s_tdata  = '0;
    logic [1:0]                 s_tuser  = '0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [sds_pkg::DATA_W-1:0] m_tdata;
    logic [1:0]                 m_tuser;

    dual_stack_scoreboard sb = new();
    int unsigned          cycle_count = 0;
    int unsigned          tx_count    = 0;
    int unsigned          rx_count    = 0;
    bit                   tx_burst    = 1'b0;
    bit                   rx_burst    = 1'b0;

    shared_dual_stack dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timed out after %0d cycles with %0d results outstanding.",
                 cycle_count, sb.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_item(input logic op, input logic which,
                             input logic [sds_pkg::DATA_W-1:0] value);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {which, op};
        s_tdata  <= value;
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.apply_stack_op(op, which, value);
        tx_count++;
        if (tx_count % 50 == 0) begin
            tx_burst = ($urandom_range(0, 2) == 0);
        end
    endtask

    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic send_random(input int unsigned count);
        repeat (count) begin
            send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom());
        end
    endtask

    // The receiver holds off once for a long stretch so that the block fills and
    // stops accepting transactions while the sender keeps offering them.
    initial begin : result_sink
        int gap;
        bit held_off;
        held_off = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (!held_off && rx_count >= 300) begin
                gap      = 120;
                held_off = 1'b1;
            end else begin
                gap = rx_burst ? 0 : $urandom_range(0, 8);
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            sb.check_result(m_tdata, m_tuser);
            rx_count++;
            if (rx_count % 40 == 0) begin
                rx_burst = ($urandom_range(0, 2) == 0);
            end
        end
    end

    initial begin : stimulus
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        send_item(sds_pkg::OP_POP,  sds_pkg::STACK_LOWER, 32'hFFFF_FFFF);
        send_item(sds_pkg::OP_POP,  sds_pkg::STACK_UPPER, 32'h0000_0000);
        send_item(sds_pkg::OP_PUSH, sds_pkg::STACK_LOWER, 32'h7FFF_FFFF);
        send_item(sds_pkg::OP_PUSH, sds_pkg::STACK_LOWER, 32'h8000_0000);
        send_item(sds_pkg::OP_PUSH, sds_pkg::STACK_UPPER, 32'hFFFF_FFFF);
        send_item(sds_pkg::OP_PUSH, sds_pkg::STACK_UPPER, 32'h0000_0000);
        send_item(sds_pkg::OP_PUSH, sds_pkg::STACK_UPPER, 32'h8000_0001);
        send_item(sds_pkg::OP_POP,  sds_pkg::STACK_LOWER, 32'hFFFF_FFFF);
        send_item(sds_pkg::OP_POP,  sds_pkg::STACK_LOWER, 32'h0000_0000);
        send_item(sds_pkg::OP_POP,  sds_pkg::STACK_LOWER, 32'h5555_5555);
        send_item(sds_pkg::OP_POP,  sds_pkg::STACK_UPPER, 32'hAAAA_AAAA);
        send_item(sds_pkg::OP_PUSH, sds_pkg::STACK_LOWER, 32'hA5A5_A5A5);
        send_item(sds_pkg::OP_POP,  sds_pkg::STACK_UPPER, 32'hFFFF_FFFF);
        send_item(sds_pkg::OP_POP,  sds_pkg::STACK_UPPER, 32'h0000_0000);
        send_item(sds_pkg::OP_POP,  sds_pkg::STACK_UPPER, 32'h1234_5678);
        send_item(sds_pkg::OP_POP,  sds_pkg::STACK_LOWER, 32'h0000_0001);
        send_item(sds_pkg::OP_POP,  sds_pkg::STACK_LOWER, 32'h8000_0000);
        pause_until_drained();

        send_random(20);
        pause_until_drained();

        // Fill the shared memory from both ends until it is full.
        while (sb.lower_held + sb.upper_held < sds_pkg::DEPTH) begin
            if ($urandom_range(0, 63) == 0) begin
                send_item(sds_pkg::OP_POP, 1'($urandom_range(0, 1)), $urandom());
            end else begin
                send_item(sds_pkg::OP_PUSH, 1'($urandom_range(0, 1)), $urandom());
            end
        end

        send_random(20);
        pause_until_drained();
        repeat (10) @(posedge aclk);

        $display("Ran %0d transactions through both stacks, peak fill %0d of %0d words.",
                 tx_count, sb.peak_held, sds_pkg::DEPTH);
        $display("Saw %0d pops with data, %0d overflows and %0d underflows.",
                 sb.good_pops, sb.overflows, sb.underflows);
        if (sb.pending() != 0) begin
            $display("%0d expected results never arrived.", sb.pending());
        end
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* files.f */
sv/sds_pkg.sv
sv/sds_ram.sv
sv/sds_ctrl.sv
sv/shared_dual_stack.sv
sv/sds_checker.sv
test/tb_top.sv
